FILE: hdl/vector_angle_degrees_macros.svh
// Assertion helpers for the RTL files; vad_final includes them.
`ifndef VECTOR_ANGLE_DEGREES_MACROS_SVH
`define VECTOR_ANGLE_DEGREES_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define VAD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, forces a consequence in the following cycle.
`define VAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/vad_pkg.sv
`default_nettype none

package vad_pkg;

  localparam int unsigned ROTATION_STAGES = 14;
  localparam int unsigned TABLE_LEN       = 24;
  localparam int unsigned GUARD_BITS      = 8;

  localparam int unsigned IN_W      = 16;
  localparam int unsigned HEAD_W    = 16;
  localparam int unsigned MAG_W     = IN_W + 1;
  localparam int unsigned XW        = 27;
  localparam int unsigned ZW        = 24;
  localparam int unsigned STAGE_W   = $clog2(TABLE_LEN);
  localparam int unsigned NUM_CELLS =
    (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;

  localparam logic [HEAD_W-1:0] HEAD_0     = HEAD_W'(0);
  localparam logic [HEAD_W-1:0] HEAD_90    = HEAD_W'(90 * 128);
  localparam logic [HEAD_W-1:0] HEAD_180   = HEAD_W'(180 * 128);
  localparam logic [HEAD_W-1:0] HEAD_270   = HEAD_W'(270 * 128);
  localparam logic [HEAD_W:0]   FULL_TURN  = (HEAD_W + 1)'(360 * 128);
  localparam logic signed [ZW-1:0] Z_MAX   = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Z_ROUND = ZW'(256);

  typedef struct packed {
    logic                   special;
    logic [HEAD_W-1:0]      offset;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } vad_lane_t;

  // Arctangent of 2^-i in units of 2^-16 degree, rounded.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
    logic signed [ZW-1:0] e;
    case (idx)
      5'd0:    e = ZW'(2949120);
      5'd1:    e = ZW'(1740967);
      5'd2:    e = ZW'(919879);
      5'd3:    e = ZW'(466945);
      5'd4:    e = ZW'(234379);
      5'd5:    e = ZW'(117304);
      5'd6:    e = ZW'(58666);
      5'd7:    e = ZW'(29335);
      5'd8:    e = ZW'(14668);
      5'd9:    e = ZW'(7334);
      5'd10:   e = ZW'(3667);
      5'd11:   e = ZW'(1833);
      5'd12:   e = ZW'(917);
      5'd13:   e = ZW'(458);
      5'd14:   e = ZW'(229);
      5'd15:   e = ZW'(115);
      5'd16:   e = ZW'(57);
      5'd17:   e = ZW'(29);
      5'd18:   e = ZW'(14);
      5'd19:   e = ZW'(7);
      5'd20:   e = ZW'(4);
      5'd21:   e = ZW'(2);
      5'd22:   e = ZW'(1);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/vad_fold.sv
`default_nettype none

module vad_fold import vad_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic signed [IN_W-1:0] vel_x_i,
  input  wire logic signed [IN_W-1:0] vel_y_i,
  output logic                        valid_o,
  output vad_lane_t                   lane_o
);

  logic                    valid_q;
  vad_lane_t               lane_q, lane_d;
  logic signed [MAG_W-1:0] xe, ye, xn, yn, mag_a, mag_b;

  always_comb begin
    xe = MAG_W'(vel_x_i);
    ye = MAG_W'(vel_y_i);
    xn = -xe;
    yn = -ye;
    lane_d.special = (vel_x_i == '0) || (vel_y_i == '0);
    lane_d.z       = '0;
    if (vel_x_i == '0) begin
      lane_d.offset = vel_y_i[IN_W-1] ? HEAD_270 : HEAD_90;
    end else if (vel_y_i == '0) begin
      lane_d.offset = vel_x_i[IN_W-1] ? HEAD_180 : HEAD_0;
    end else if (!vel_x_i[IN_W-1] && !vel_y_i[IN_W-1]) begin
      lane_d.offset = HEAD_0;
    end else if (vel_x_i[IN_W-1] && !vel_y_i[IN_W-1]) begin
      lane_d.offset = HEAD_90;
    end else if (vel_x_i[IN_W-1]) begin
      lane_d.offset = HEAD_180;
    end else begin
      lane_d.offset = HEAD_270;
    end
    if (!vel_x_i[IN_W-1] && !vel_y_i[IN_W-1]) begin
      mag_a = xe;
      mag_b = ye;
    end else if (vel_x_i[IN_W-1] && !vel_y_i[IN_W-1]) begin
      mag_a = ye;
      mag_b = xn;
    end else if (vel_x_i[IN_W-1]) begin
      mag_a = xn;
      mag_b = yn;
    end else begin
      mag_a = yn;
      mag_b = xe;
    end
    lane_d.x = XW'(mag_a) <<< GUARD_BITS;
    lane_d.y = XW'(mag_b) <<< GUARD_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

FILE: hdl/vad_cell.sv
`default_nettype none

module vad_cell import vad_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [STAGE_W-1:0] stage_i,
  input  wire logic               valid_i,
  input  wire vad_lane_t          lane_i,
  output logic                    valid_o,
  output vad_lane_t               lane_o
);

  logic                 valid_q;
  vad_lane_t            lane_q, lane_d;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] entry;

  always_comb begin
    xs     = lane_i.x >>> stage_i;
    ys     = lane_i.y >>> stage_i;
    entry  = atan_entry(stage_i);
    lane_d = lane_i;
    if (lane_i.y > 0) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + entry;
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

FILE: hdl/vad_final.sv
`default_nettype none
`include "vector_angle_degrees_macros.svh"

module vad_final import vad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire vad_lane_t   lane_i,
  output logic             valid_o,
  output logic [HEAD_W-1:0] heading_o
);

  logic                 valid_q;
  logic                 special_q;
  logic [HEAD_W-1:0]    heading_q, heading_d;
  logic signed [ZW-1:0] zc, zr;
  logic [HEAD_W:0]      sum;

  always_comb begin
    if (lane_i.z < 0) begin
      zc = '0;
    end else if (lane_i.z > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = lane_i.z;
    end
    zr  = zc + Z_ROUND;
    sum = (HEAD_W + 1)'(lane_i.offset) + (HEAD_W + 1)'(zr[ZW-1:9]);
    if (lane_i.special) begin
      heading_d = lane_i.offset;
    end else if (sum >= FULL_TURN) begin
      heading_d = HEAD_W'(sum - FULL_TURN);
    end else begin
      heading_d = sum[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      heading_q <= heading_d;
      special_q <= lane_i.special;
    end
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;

  `VAD_ASSERT_ALWAYS(a_heading_range, clk_i, rst_ni,
    !valid_q || ({1'b0, heading_q} < FULL_TURN), "Heading beyond a full turn.")
  `VAD_ASSERT_ALWAYS(a_special_axis, clk_i, rst_ni,
    !(valid_q && special_q) ||
    (heading_q == HEAD_0) || (heading_q == HEAD_90) ||
    (heading_q == HEAD_180) || (heading_q == HEAD_270),
    "Axis vector off an axis heading.")
  `VAD_ASSERT_NEXT(a_result_lands, clk_i, rst_ni,
    en_i && valid_i, valid_q, "Finished request lost at the output register.")

endmodule

`default_nettype wire

FILE: hdl/vector_angle_degrees.sv
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_stall_o     vel_x_i, vel_y_i (signed Q8.8)
// output    out        out_valid_o / out_stall_i   heading_o (1/128 degree)
//
// One request is taken per cycle while in_stall_o is low; each result passes through
// the fold register, one register per rotation cell and the output register.
// Reset clears the valid bits of every stage; data registers are not reset.
// A stall at the output while a result waits there freezes the whole chain,
// and in_stall_o rises in the same cycle.
`default_nettype none

module vector_angle_degrees import vad_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [IN_W-1:0] vel_x_i,
  input  wire logic signed [IN_W-1:0] vel_y_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [HEAD_W-1:0]           heading_o
);

  logic      adv;
  logic      valid_c [NUM_CELLS+1];
  vad_lane_t lane_c  [NUM_CELLS+1];

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  vad_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .vel_x_i (vel_x_i),
    .vel_y_i (vel_y_i),
    .valid_o (valid_c[0]),
    .lane_o  (lane_c[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    vad_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (STAGE_W'(g)),
      .valid_i (valid_c[g]),
      .lane_i  (lane_c[g]),
      .valid_o (valid_c[g+1]),
      .lane_o  (lane_c[g+1])
    );
  end

  vad_final u_final (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (valid_c[NUM_CELLS]),
    .lane_i    (lane_c[NUM_CELLS]),
    .valid_o   (out_valid_o),
    .heading_o (heading_o)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench import vad_pkg::*; ();

  typedef struct {
    logic signed [IN_W-1:0] vx;
    logic signed [IN_W-1:0] vy;
    logic [HEAD_W-1:0]      heading;
  } heading_rec_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [IN_W-1:0] vel_x_i = '0;
  logic signed [IN_W-1:0] vel_y_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [HEAD_W-1:0]      heading_o;

  heading_rec_t heading_queue [$];
  heading_rec_t want_rec;
  bit           gaps_on = 1'b1;
  int unsigned  mismatch_count = 0;
  int unsigned  sent_count = 0;
  int unsigned  checked_count = 0;
  int unsigned  stalled_cycles = 0;

  // Arctangent of 2^-i in units of 2^-16 degree.
  longint arctan_step [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  vector_angle_degrees DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .heading_o   (heading_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [HEAD_W-1:0] predict_heading(logic signed [IN_W-1:0] vx,
                                                        logic signed [IN_W-1:0] vy);
    longint sx;
    longint sy;
    longint ra;
    longint rb;
    longint shx;
    longint shy;
    longint z;
    longint base_deg;
    longint part;
    sx = vx;
    sy = vy;
    z = 0;
    if (sx == 0) begin
      return (sy < 0) ? HEAD_270 : HEAD_90;
    end
    if (sy == 0) begin
      return (sx < 0) ? HEAD_180 : HEAD_0;
    end
    // Fold the vector into the first quadrant and note the base angle.
    if (sx > 0 && sy > 0) begin
      base_deg = 0;   ra = sx;  rb = sy;
    end else if (sx < 0 && sy > 0) begin
      base_deg = 90;  ra = sy;  rb = -sx;
    end else if (sx < 0) begin
      base_deg = 180; ra = -sx; rb = -sy;
    end else begin
      base_deg = 270; ra = -sy; rb = sx;
    end
    ra = ra <<< GUARD_BITS;
    rb = rb <<< GUARD_BITS;
    for (int i = 0; i < NUM_CELLS; i++) begin
      shx = ra >>> i;
      shy = rb >>> i;
      if (rb > 0) begin
        ra = ra + shy;
        rb = rb - shx;
        z  = z + arctan_step[i];
      end else begin
        ra = ra - shy;
        rb = rb + shx;
        z  = z - arctan_step[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    part = (z + 256) >>> 9;
    return HEAD_W'((base_deg * 128 + part) % (360 * 128));
  endfunction

  function automatic logic signed [IN_W-1:0] random_component();
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = IN_W'($urandom_range(0, 16)) - IN_W'(8);
      2: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      3: v = $urandom_range(0, 1) ? 16'sh7FFE : 16'sh8001;
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 20) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic send_vector(input logic signed [IN_W-1:0] vx,
                             input logic signed [IN_W-1:0] vy);
    heading_rec_t rec;
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vel_x_i    <= vx;
    vel_y_i    <= vy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rec.vx = vx;
    rec.vy = vy;
    rec.heading = predict_heading(vx, vy);
    heading_queue.push_back(rec);
    sent_count++;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(0, 99) < 23);
    if (rst_ni && out_stall_i) stalled_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (heading_queue.size() == 0) begin
        report_mismatch($sformatf("heading %0d with no request outstanding", heading_o));
      end else begin
        want_rec = heading_queue.pop_front();
        checked_count++;
        if (heading_o !== want_rec.heading) begin
          report_mismatch($sformatf("vel (%0d, %0d): heading %0d, predicted %0d",
                                    want_rec.vx, want_rec.vy, heading_o, want_rec.heading));
        end
      end
    end
  end

  // The axes, the zero vector, the diagonals, the extremes and the wrap to a full turn.
  task automatic test_axis_and_corners();
    send_vector(16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd1);
    send_vector(16'sd0, -16'sd1);
    send_vector(16'sd0, 16'sh7FFF);
    send_vector(16'sd0, 16'sh8000);
    send_vector(16'sd1, 16'sd0);
    send_vector(-16'sd1, 16'sd0);
    send_vector(16'sh7FFF, 16'sd0);
    send_vector(16'sh8000, 16'sd0);
    send_vector(16'sd1, 16'sd1);
    send_vector(-16'sd1, 16'sd1);
    send_vector(-16'sd1, -16'sd1);
    send_vector(16'sd1, -16'sd1);
    send_vector(16'sh7FFF, 16'sh7FFF);
    send_vector(16'sh8000, 16'sh8000);
    send_vector(16'sh8000, 16'sh7FFF);
    send_vector(16'sh7FFF, 16'sh8000);
    send_vector(16'sh7FFF, -16'sd1);
    send_vector(16'sh8000, 16'sd1);
    send_vector(16'sd1, 16'sh7FFF);
    send_vector(-16'sd1, 16'sh8000);
    send_vector(16'sh5555, -16'sh2AAA);
  endtask

  task automatic test_random_with_gaps(input int unsigned count);
    gaps_on = 1'b1;
    repeat (count) send_vector(random_component(), random_component());
  endtask

  task automatic test_streaming(input int unsigned count);
    gaps_on = 1'b0;
    repeat (count) send_vector(random_component(), random_component());
    gaps_on = 1'b1;
  endtask

  task automatic test_small_vectors(input int unsigned count);
    logic signed [IN_W-1:0] vx;
    logic signed [IN_W-1:0] vy;
    repeat (count) begin
      vx = IN_W'($urandom_range(0, 16)) - IN_W'(8);
      vy = IN_W'($urandom_range(0, 16)) - IN_W'(8);
      send_vector(vx, vy);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_axis_and_corners();
    test_random_with_gaps(600);
    test_streaming(300);
    test_small_vectors(200);
    test_random_with_gaps(200);
    in_valid_i <= 1'b0;
    while (heading_queue.size() != 0) @(posedge clk_i);
    repeat (ROTATION_STAGES + 6) @(posedge clk_i);
    $display("Sent %0d vectors over all quadrants, axes and extremes; checked %0d headings.",
             sent_count, checked_count);
    $display("Output was held back on %0d cycles; one stretch ran with no gaps at all.",
             stalled_cycles);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d headings outstanding.", heading_queue.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
